FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the Sharpe ratio block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRA_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Widths, item types and state codes for the Sharpe ratio accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

    // Set-up of the sample stream
    localparam int SAMPLE_WIDTH = 24;
    localparam int MAX_SAMPLES  = 65536;

    // Fixed field widths of the items
    localparam int IN_W   = 24;
    localparam int OUT_W  = 32;
    localparam int CNT_W  = 17;
    localparam int FRAC_W = 16;

    // Accumulator widths, sized so that a full set never wraps
    localparam int LOG_MAX = $clog2(MAX_SAMPLES);
    localparam int SUM_W   = SAMPLE_WIDTH + LOG_MAX;
    localparam int SQR_W   = 2 * SAMPLE_WIDTH - 1;
    localparam int SQ_W    = SQR_W + LOG_MAX;

    // Result engine widths
    localparam int PROD_W = CNT_W + SQ_W;
    localparam int MPL_W  = (SUM_W > CNT_W) ? SUM_W : CNT_W;
    localparam int ROOT_W = PROD_W + 2 * OUT_W;
    localparam int BIT_W  = $clog2(OUT_W);

    // Queue of set totals between the two halves
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Saturation limits of the signed result
    localparam logic [OUT_W-1:0] NEG_LIMIT   = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] POS_LIMIT   = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_SAMPLES);

    // Input item
    typedef struct packed {
        logic signed [IN_W-1:0] return_sample;
        logic                   last_sample;
    } sample_item_t;

    // Result item
    typedef struct packed {
        logic signed [OUT_W-1:0] sharpe;
        logic                    zero_spread;
        logic [CNT_W-1:0]        sample_count;
    } result_item_t;

    // Totals of one completed set
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         square_sum;
        logic [CNT_W-1:0]        count;
    } set_totals_t;

    // Result engine states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_NQ,
        BK_MUL_SS,
        BK_ROOT_INIT,
        BK_ROOT_ADD,
        BK_ROOT_SUB,
        BK_FINISH
    } back_state_t;

endpackage

`default_nettype wire

FILE: sv/sharpe_ratio_accumulator_unit.sv
// ----------------------------------------------------------------------------
// sharpe_ratio_accumulator_unit
// Sharpe ratio (mean over population standard deviation) of sets of Q8.16
// return samples, given in saturated Q16.16.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while sample_stall is low into a
// three-stage accumulator (capture, square, accumulate) that keeps an exact
// sum, sum of squares and count; a sample beyond 65536 in one set is
// dropped. When the flagged last sample reaches the accumulator the set
// totals go into a two-entry queue and the accumulator starts the next set
// at once. A result engine takes the totals from the queue and works out
// sum/sqrt(n*sumsq - sum^2): it loads them, runs a shift-add multiplier over
// the bits of the count and then over the bits of the magnitude of the sum,
// tests for a zero spread, then finds the 32 result bits with a trial add
// and a trial subtract for each, and loads the output register; a zero
// spread skips the root search. Sets that arrive no faster than the
// engine clears them run at one sample per clock; when shorter sets arrive
// faster than the engine clears them the queue fills and sample_stall is
// raised. A result waiting in the output register holds the engine, and so
// blocks the accumulator only once the queue has filled up behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module sharpe_ratio_accumulator_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sra_pkg::sample_item_t sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output sra_pkg::result_item_t result
);

    logic                 push;
    logic                 full;
    logic                 pop;
    logic                 empty;
    sra_pkg::set_totals_t push_data;
    sra_pkg::set_totals_t pop_data;

    // Sample accumulator
    sra_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .push         (push),
        .push_data    (push_data),
        .full         (full)
    );

    // Queue of finished set totals
    sra_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Ratio engine and output register
    sra_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop          (pop),
        .pop_data     (pop_data),
        .empty        (empty),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: sv/sra_queue.sv
// ----------------------------------------------------------------------------
// sra_queue
// Short queue of completed set totals between the accumulator and the
// result engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sra_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sra_pkg::set_totals_t push_data,
    output logic                 full,
    input  logic                 pop,
    output sra_pkg::set_totals_t pop_data,
    output logic                 empty
);

    sra_pkg::set_totals_t                 entry_reg [sra_pkg::QUEUE_DEPTH];
    logic [sra_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg;
    logic [sra_pkg::QUEUE_PTR_W-1:0]      wr_ptr_next;
    logic [sra_pkg::QUEUE_PTR_W-1:0]      rd_ptr_reg;
    logic [sra_pkg::QUEUE_PTR_W-1:0]      rd_ptr_next;
    logic [sra_pkg::QUEUE_CNT_W-1:0]      count_reg;
    logic [sra_pkg::QUEUE_CNT_W-1:0]      count_next;

    // Status flags
    assign full     = (count_reg == sra_pkg::QUEUE_CNT_W'(sra_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == sra_pkg::QUEUE_PTR_W'(sra_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == sra_pkg::QUEUE_PTR_W'(sra_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Checks
    `SRA_ASSERT_IMPLY(a_push_not_full, clk, rst_n, push, !full, "set totals pushed into a full queue")
    `SRA_ASSERT_IMPLY(a_pop_not_empty, clk, rst_n, pop, !empty, "set totals popped from an empty queue")
    `SRA_ASSERT_NEXT(a_count_rises, clk, rst_n, push && !pop, count_reg == sra_pkg::QUEUE_CNT_W'($past(count_reg) + 1'b1), "queue fill count did not follow a push")

endmodule

`default_nettype wire

FILE: sv/sra_front.sv
// ----------------------------------------------------------------------------
// sra_front
// Accepts return samples, squares them and keeps the running sum, sum of
// squares and count; hands the totals of each finished set to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sra_pkg::sample_item_t sample,
    output logic                 push,
    output sra_pkg::set_totals_t push_data,
    input  logic                 full
);

    logic hold;
    logic advance;
    logic accept;

    // Stage one: captured sample
    logic                                   s1_valid_reg;
    logic                                   s1_valid_next;
    logic                                   s1_last_reg;
    logic signed [sra_pkg::SAMPLE_WIDTH-1:0] s1_x_reg;

    // Stage two: sample and its square
    logic                                   s2_valid_reg;
    logic                                   s2_valid_next;
    logic                                   s2_last_reg;
    logic signed [sra_pkg::SAMPLE_WIDTH-1:0] s2_x_reg;
    logic [sra_pkg::SQR_W-1:0]              s2_sq_reg;
    logic signed [2*sra_pkg::SAMPLE_WIDTH-1:0] square;

    // Running totals
    logic signed [sra_pkg::SUM_W-1:0] sum_reg;
    logic signed [sra_pkg::SUM_W-1:0] sum_next;
    logic [sra_pkg::SQ_W-1:0]         sq_sum_reg;
    logic [sra_pkg::SQ_W-1:0]         sq_sum_next;
    logic [sra_pkg::CNT_W-1:0]        count_reg;
    logic [sra_pkg::CNT_W-1:0]        count_next;

    logic                             room;
    logic signed [sra_pkg::SUM_W-1:0] sum_total;
    logic [sra_pkg::SQ_W-1:0]         sq_total;
    logic [sra_pkg::CNT_W-1:0]        count_total;

    // The pipe freezes only when a finished set cannot enter the queue
    assign hold         = s2_valid_reg && s2_last_reg && full;
    assign advance      = !hold;
    assign accept       = sample_valid && advance;
    assign sample_stall = hold;

    // Square of the captured sample
    assign square = s1_x_reg * s1_x_reg;

    // Totals including the sample in stage two; samples past the limit are dropped
    assign room = (count_reg < sra_pkg::COUNT_LIMIT);

    always_comb
    begin
        sum_total   = sum_reg;
        sq_total    = sq_sum_reg;
        count_total = count_reg;
        if (room)
        begin
            sum_total   = sum_reg + {{(sra_pkg::SUM_W - sra_pkg::SAMPLE_WIDTH)
                                      {s2_x_reg[sra_pkg::SAMPLE_WIDTH-1]}}, s2_x_reg};
            sq_total    = sq_sum_reg + sra_pkg::SQ_W'(s2_sq_reg);
            count_total = count_reg + 1'b1;
        end
    end

    // Hand-over of a finished set
    assign push                 = s2_valid_reg && s2_last_reg && !full;
    assign push_data.sum        = sum_total;
    assign push_data.square_sum = sq_total;
    assign push_data.count      = count_total;

    // Next state of the stages and the totals
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        sum_next      = sum_reg;
        sq_sum_next   = sq_sum_reg;
        count_next    = count_reg;
        if (advance)
        begin
            s1_valid_next = accept;
            s2_valid_next = s1_valid_reg;
            if (s2_valid_reg)
            begin
                if (s2_last_reg)
                begin
                    sum_next    = '0;
                    sq_sum_next = '0;
                    count_next  = '0;
                end
                else
                begin
                    sum_next    = sum_total;
                    sq_sum_next = sq_total;
                    count_next  = count_total;
                end
            end
        end
    end

    // Control and accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
            sq_sum_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            sum_reg      <= sum_next;
            sq_sum_reg   <= sq_sum_next;
            count_reg    <= count_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= sample.return_sample[sra_pkg::SAMPLE_WIDTH-1:0];
            s1_last_reg <= sample.last_sample;
        end
        if (advance && s1_valid_reg)
        begin
            s2_x_reg    <= s1_x_reg;
            s2_sq_reg   <= square[sra_pkg::SQR_W-1:0];
            s2_last_reg <= s1_last_reg;
        end
    end

endmodule

`default_nettype wire

FILE: sv/sra_back.sv
// ----------------------------------------------------------------------------
// sra_back
// Result engine: forms n*Q - S*S with a shift-add multiplier, then finds the
// ratio S/sqrt(n*Q - S*S) in Q16.16 one bit at a time and saturates it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sra_back (
    input  logic                  clk,
    input  logic                  rst_n,
    output logic                  pop,
    input  sra_pkg::set_totals_t  pop_data,
    input  logic                  empty,
    output logic                  result_valid,
    input  logic                  result_stall,
    output sra_pkg::result_item_t result
);

    sra_pkg::back_state_t state_reg;
    sra_pkg::back_state_t state_next;

    // Set being worked on
    logic                         neg_reg;
    logic                         neg_next;
    logic [sra_pkg::CNT_W-1:0]    count_reg;
    logic [sra_pkg::CNT_W-1:0]    count_next;
    logic [sra_pkg::SUM_W-1:0]    s_abs_reg;
    logic [sra_pkg::SUM_W-1:0]    s_abs_next;
    logic [sra_pkg::SUM_W-1:0]    sum_abs;

    // Shift-add multiplier
    logic [sra_pkg::PROD_W-1:0]   acc_reg;
    logic [sra_pkg::PROD_W-1:0]   acc_next;
    logic [sra_pkg::PROD_W-1:0]   acc_step;
    logic [sra_pkg::PROD_W-1:0]   mcand_reg;
    logic [sra_pkg::PROD_W-1:0]   mcand_next;
    logic [sra_pkg::MPL_W-1:0]    mplier_reg;
    logic [sra_pkg::MPL_W-1:0]    mplier_next;
    logic [sra_pkg::PROD_W-1:0]   spread_reg;
    logic [sra_pkg::PROD_W-1:0]   spread_next;

    // Bitwise root search
    logic [sra_pkg::ROOT_W-1:0]   rem_reg;
    logic [sra_pkg::ROOT_W-1:0]   rem_next;
    logic [sra_pkg::ROOT_W-1:0]   a_reg;
    logic [sra_pkg::ROOT_W-1:0]   a_next;
    logic [sra_pkg::ROOT_W-1:0]   dsh_reg;
    logic [sra_pkg::ROOT_W-1:0]   dsh_next;
    logic [sra_pkg::ROOT_W-1:0]   term_reg;
    logic [sra_pkg::ROOT_W-1:0]   term_next;
    logic [sra_pkg::ROOT_W:0]     diff;
    logic [sra_pkg::ROOT_W-1:0]   a_half_plus;
    logic                         take;
    logic [sra_pkg::BIT_W-1:0]    bit_reg;
    logic [sra_pkg::BIT_W-1:0]    bit_next;
    logic [sra_pkg::OUT_W-1:0]    m_reg;
    logic [sra_pkg::OUT_W-1:0]    m_next;
    logic                         zero_reg;
    logic                         zero_next;

    // Result output register
    logic [sra_pkg::OUT_W-1:0]        mag;
    logic signed [sra_pkg::OUT_W-1:0] sharpe_sat;
    sra_pkg::result_item_t            result_reg;
    sra_pkg::result_item_t            result_next;
    logic                             result_valid_reg;
    logic                             result_valid_next;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Magnitude of the incoming sum
    assign sum_abs = pop_data.sum[sra_pkg::SUM_W-1] ? -pop_data.sum : pop_data.sum;

    // One multiplier step
    assign acc_step = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    // One root step: trial subtraction and the updated cross term in parallel
    assign diff        = {1'b0, rem_reg} - {1'b0, term_reg};
    assign take        = !diff[sra_pkg::ROOT_W];
    assign a_half_plus = (a_reg >> 1) + dsh_reg;

    // Saturation of the signed ratio
    always_comb
    begin
        if (neg_reg)
        begin
            mag        = (m_reg > sra_pkg::NEG_LIMIT) ? sra_pkg::NEG_LIMIT : m_reg;
            sharpe_sat = -mag;
        end
        else
        begin
            mag        = (m_reg > sra_pkg::POS_LIMIT) ? sra_pkg::POS_LIMIT : m_reg;
            sharpe_sat = mag;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        neg_next          = neg_reg;
        count_next        = count_reg;
        s_abs_next        = s_abs_reg;
        acc_next          = acc_reg;
        mcand_next        = mcand_reg;
        mplier_next       = mplier_reg;
        spread_next       = spread_reg;
        rem_next          = rem_reg;
        a_next            = a_reg;
        dsh_next          = dsh_reg;
        term_next         = term_reg;
        bit_next          = bit_reg;
        m_next            = m_reg;
        zero_next         = zero_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        pop               = 1'b0;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            sra_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    pop         = 1'b1;
                    neg_next    = pop_data.sum[sra_pkg::SUM_W-1];
                    s_abs_next  = sum_abs;
                    count_next  = pop_data.count;
                    acc_next    = '0;
                    mcand_next  = sra_pkg::PROD_W'(pop_data.square_sum);
                    mplier_next = sra_pkg::MPL_W'(pop_data.count);
                    state_next  = sra_pkg::BK_MUL_NQ;
                end
            end

            // n times the sum of squares
            sra_pkg::BK_MUL_NQ:
            begin
                if (mplier_reg == '0)
                begin
                    spread_next = acc_reg;
                    acc_next    = '0;
                    mcand_next  = sra_pkg::PROD_W'(s_abs_reg);
                    mplier_next = sra_pkg::MPL_W'(s_abs_reg);
                    state_next  = sra_pkg::BK_MUL_SS;
                end
                else
                begin
                    acc_next    = acc_step;
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end

            // Square of the sum, then the spread n*Q - S*S
            sra_pkg::BK_MUL_SS:
            begin
                if (mplier_reg == '0)
                begin
                    spread_next = spread_reg - acc_reg;
                    state_next  = sra_pkg::BK_ROOT_INIT;
                end
                else
                begin
                    acc_next    = acc_step;
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end

            // Zero spread short-cuts; otherwise seed the root search
            sra_pkg::BK_ROOT_INIT:
            begin
                m_next = '0;
                if (spread_reg == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = sra_pkg::BK_FINISH;
                end
                else
                begin
                    zero_next  = 1'b0;
                    rem_next   = sra_pkg::ROOT_W'(acc_reg) << (2 * sra_pkg::FRAC_W);
                    a_next     = '0;
                    dsh_next   = sra_pkg::ROOT_W'(spread_reg) << (2 * (sra_pkg::OUT_W - 1));
                    bit_next   = sra_pkg::BIT_W'(sra_pkg::OUT_W - 1);
                    state_next = sra_pkg::BK_ROOT_ADD;
                end
            end

            // Trial term for the current result bit
            sra_pkg::BK_ROOT_ADD:
            begin
                term_next  = a_reg + dsh_reg;
                state_next = sra_pkg::BK_ROOT_SUB;
            end

            // Keep the bit if the trial term fits in the remainder
            sra_pkg::BK_ROOT_SUB:
            begin
                if (take)
                begin
                    rem_next = diff[sra_pkg::ROOT_W-1:0];
                    a_next   = a_half_plus;
                end
                else
                begin
                    a_next = a_reg >> 1;
                end
                dsh_next = dsh_reg >> 2;
                m_next   = {m_reg[sra_pkg::OUT_W-2:0], take};
                if (bit_reg == '0)
                begin
                    state_next = sra_pkg::BK_FINISH;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = sra_pkg::BK_ROOT_ADD;
                end
            end

            // Load the output register once it is free
            sra_pkg::BK_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.sharpe       = sharpe_sat;
                    result_next.zero_spread  = zero_reg;
                    result_next.sample_count = count_reg;
                    result_valid_next        = 1'b1;
                    state_next               = sra_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = sra_pkg::BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sra_pkg::BK_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        count_reg  <= count_next;
        s_abs_reg  <= s_abs_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        spread_reg <= spread_next;
        rem_reg    <= rem_next;
        a_reg      <= a_next;
        dsh_reg    <= dsh_next;
        term_reg   <= term_next;
        bit_reg    <= bit_next;
        m_reg      <= m_next;
        zero_reg   <= zero_next;
        result_reg <= result_next;
    end

    // Checks
    `SRA_ASSERT_IMPLY(a_result_from_finish, clk, rst_n, $rose(result_valid_reg), $past(state_reg) == sra_pkg::BK_FINISH, "result appeared without a finished computation")
    `SRA_ASSERT_IMPLY(a_zero_spread_value, clk, rst_n, result_valid_reg && result_reg.zero_spread, result_reg.sharpe == '0, "zero spread result carries a nonzero ratio")
    `SRA_ASSERT_IMPLY(a_root_term_live, clk, rst_n, state_reg == sra_pkg::BK_ROOT_ADD, dsh_reg != '0, "root search running with a vanished spread term")

endmodule

`default_nettype wire

FILE: sim/sharpe_ratio_accumulator_unit_tb.sv
// ----------------------------------------------------------------------------
// sharpe_ratio_accumulator_unit_tb
// Self-checking bench for the Sharpe ratio accumulator. Sets of return
// samples are sent to the block. A running model keeps the exact sum, the
// sum of squares and the count of each set, and forms the expected ratio.
// Every result item is checked field by field against the oldest ratio still
// owed. Both sides idle at random, and the output is held off for one long
// stretch so that the block backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module sharpe_ratio_accumulator_unit_tb;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_SAMPLES  = 1430;
    localparam int IDLE_LIMIT      = 3000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int HOLD_OFF_CYCLES = 400;

    localparam logic [sra_pkg::IN_W-1:0] SAMPLE_TOP    = {1'b0, {(sra_pkg::IN_W-1){1'b1}}};
    localparam logic [sra_pkg::IN_W-1:0] SAMPLE_BOTTOM = {1'b1, {(sra_pkg::IN_W-1){1'b0}}};

    // How the values of one random set are chosen
    typedef enum int {
        VAL_ANY,
        VAL_SMALL,
        VAL_NEAR,
        VAL_FLAT,
        VAL_EXTREME
    } value_mode_t;

    // Running model of the accumulator and store of the ratios still owed.
    class sharpe_tracker;
        bit signed [63:0]      set_sum;
        bit [63:0]             set_square_sum;
        int unsigned           set_count;
        sra_pkg::result_item_t ratios_due[$];
        int unsigned           mismatches;
        int unsigned           ratios_checked;
        int unsigned           flat_sets;
        int unsigned           saturated_sets;

        // Exact ratio of the set held so far, truncated towards zero.
        function sra_pkg::result_item_t ratio_of_set();
            sra_pkg::result_item_t ratio;
            bit [63:0]             sum_mag;
            bit [159:0]            spread;
            bit [159:0]            target;
            bit [159:0]            trial;
            bit [31:0]             root;
            bit [31:0]             cand;
            int                    b;
            ratio = '0;
            ratio.sample_count = sra_pkg::CNT_W'(set_count);
            sum_mag = (set_sum < 0) ? 64'(-set_sum) : 64'(set_sum);
            spread = 160'(set_count) * 160'(set_square_sum)
                     - 160'(sum_mag) * 160'(sum_mag);
            if (spread == '0)
            begin
                ratio.zero_spread = 1'b1;
                flat_sets++;
                return ratio;
            end
            // Largest root with root^2 * spread <= sum^2 * 2^32
            target = (160'(sum_mag) * 160'(sum_mag)) << 32;
            root = '0;
            for (b = 31; b >= 0; b--)
            begin
                cand = root | (32'd1 << b);
                trial = 160'(cand) * 160'(cand) * spread;
                if (trial <= target)
                    root = cand;
            end
            if (set_sum < 0)
            begin
                if (root > sra_pkg::NEG_LIMIT)
                begin
                    root = sra_pkg::NEG_LIMIT;
                    saturated_sets++;
                end
                ratio.sharpe = 32'(-root);
            end
            else
            begin
                if (root > sra_pkg::POS_LIMIT)
                begin
                    root = sra_pkg::POS_LIMIT;
                    saturated_sets++;
                end
                ratio.sharpe = root;
            end
            return ratio;
        endfunction

        // Adds an accepted sample; a flagged last sample closes the set.
        function void note_sample(sra_pkg::sample_item_t item);
            bit [63:0]        raw;
            bit signed [63:0] value;
            raw = '0;
            raw[sra_pkg::IN_W-1:0] = item.return_sample;
            raw = raw & ((64'd1 << sra_pkg::SAMPLE_WIDTH) - 64'd1);
            value = signed'(raw);
            if (raw[sra_pkg::SAMPLE_WIDTH-1])
                value = value - (64'sd1 <<< sra_pkg::SAMPLE_WIDTH);
            if (set_count < sra_pkg::MAX_SAMPLES)
            begin
                set_sum += value;
                set_square_sum += 64'(value * value);
                set_count++;
            end
            if (item.last_sample)
            begin
                ratios_due = {ratios_due, ratio_of_set()};
                set_sum = '0;
                set_square_sum = '0;
                set_count = 0;
            end
        endfunction

        // Compares a result item with the oldest ratio owed.
        function void check_result(sra_pkg::result_item_t got);
            sra_pkg::result_item_t want;
            if (ratios_due.size() == 0)
            begin
                $error("result with none owed: sharpe %0d, zero_spread %0b, sample_count %0d",
                       got.sharpe, got.zero_spread, got.sample_count);
                mismatches++;
                return;
            end
            want = ratios_due.pop_front();
            ratios_checked++;
            if (got.sharpe !== want.sharpe)
            begin
                $error("sharpe: expected %0d, actual %0d", want.sharpe, got.sharpe);
                mismatches++;
            end
            if (got.zero_spread !== want.zero_spread)
            begin
                $error("zero_spread: expected %0b, actual %0b",
                       want.zero_spread, got.zero_spread);
                mismatches++;
            end
            if (got.sample_count !== want.sample_count)
            begin
                $error("sample_count: expected %0d, actual %0d",
                       want.sample_count, got.sample_count);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    sra_pkg::sample_item_t sample       = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    sra_pkg::result_item_t result;

    sharpe_tracker tracker = new;
    int unsigned   samples_sent;
    int unsigned   idle_cycles;
    bit            hold_off_request;

    sharpe_ratio_accumulator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Gap before an item: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [sra_pkg::IN_W-1:0] make_value(value_mode_t mode,
                                                             logic [sra_pkg::IN_W-1:0] base);
        int r;
        unique case (mode)
            VAL_SMALL:
                return sra_pkg::IN_W'(int'($urandom_range(0, 512)) - 256);
            VAL_NEAR:
                return base + sra_pkg::IN_W'($urandom_range(0, 3));
            VAL_FLAT:
                return base;
            VAL_EXTREME:
            begin
                r = $urandom_range(0, 4);
                if (r == 0)
                    return SAMPLE_TOP;
                else if (r == 1)
                    return SAMPLE_BOTTOM;
                else if (r == 2)
                    return '0;
                else if (r == 3)
                    return sra_pkg::IN_W'(1);
                return '1;
            end
            default:
                return sra_pkg::IN_W'($urandom);
        endcase
    endfunction

    // Offers one sample after an optional gap and waits until it is taken.
    task automatic send_sample(input logic [sra_pkg::IN_W-1:0] value, input bit last,
                               input int gap);
        sra_pkg::sample_item_t item;
        item.return_sample = value;
        item.last_sample = last;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= item;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        tracker.note_sample(item);
        samples_sent++;
    endtask

    // Results are checked as they are taken
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tracker.check_result(result);
    end

    // Count cycles in which neither side moves an item
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Receiver: random stall pattern, with one long hold-off on request.
    initial
    begin
        int r;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                result_stall <= (r >= 50);
                if (r < 50)
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                else if (r < 85)
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                else if (r < 97)
                    repeat ($urandom_range(4, 12)) @(posedge clk);
                else
                    repeat ($urandom_range(30, 80)) @(posedge clk);
            end
        end
    end

    // Sender and end of run
    initial
    begin
        int                           i;
        int                           length;
        int                           r;
        int unsigned                  random_start;
        value_mode_t                  mode;
        logic [sra_pkg::IN_W-1:0]     base;
        bit                           burst;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Single samples give a zero spread
        send_sample('0, 1'b1, pick_gap());
        send_sample(SAMPLE_TOP, 1'b1, pick_gap());
        // Neighbouring extremes drive the ratio far out of range both ways
        send_sample(SAMPLE_TOP, 1'b0, pick_gap());
        send_sample(SAMPLE_TOP - 1'b1, 1'b1, pick_gap());
        send_sample(SAMPLE_BOTTOM, 1'b0, pick_gap());
        send_sample(SAMPLE_BOTTOM + 1'b1, 1'b1, pick_gap());
        // Opposite extremes: a tiny negative ratio that truncates to zero
        send_sample(SAMPLE_BOTTOM, 1'b0, pick_gap());
        send_sample(SAMPLE_TOP, 1'b1, pick_gap());
        // Equal samples give a zero spread
        send_sample(sra_pkg::IN_W'(-5), 1'b0, pick_gap());
        send_sample(sra_pkg::IN_W'(-5), 1'b0, pick_gap());
        send_sample(sra_pkg::IN_W'(-5), 1'b1, pick_gap());
        // Zero sum with a spread
        send_sample(sra_pkg::IN_W'(3), 1'b0, pick_gap());
        send_sample(sra_pkg::IN_W'(-3), 1'b1, pick_gap());
        // Small mixed sets
        send_sample(sra_pkg::IN_W'(65536), 1'b0, pick_gap());
        send_sample(sra_pkg::IN_W'(131072), 1'b0, pick_gap());
        send_sample(sra_pkg::IN_W'(-65536), 1'b0, pick_gap());
        send_sample('0, 1'b1, pick_gap());
        send_sample('1, 1'b0, pick_gap());
        send_sample(sra_pkg::IN_W'(-2), 1'b1, pick_gap());

        // Random sets, the output held off once near the start
        hold_off_request = 1'b1;
        random_start = samples_sent;
        while (samples_sent - random_start < RANDOM_SAMPLES)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                length = $urandom_range(1, 4);
            else if (r < 85)
                length = $urandom_range(5, 16);
            else if (r < 97)
                length = $urandom_range(17, 64);
            else
                length = $urandom_range(65, 300);
            mode = value_mode_t'($urandom_range(0, 4));
            base = sra_pkg::IN_W'($urandom);
            burst = ($urandom_range(0, 3) == 0);
            for (i = 0; i < length; i++)
                send_sample(make_value(mode, base), i == length - 1,
                            burst ? 0 : pick_gap());
        end
        sample_valid <= 1'b0;

        // Wait for every owed ratio, then a little longer for strays
        while (tracker.ratios_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples and checked %0d set results (%0d zero spread, %0d saturated).",
                 samples_sent, tracker.ratios_checked, tracker.flat_sets,
                 tracker.saturated_sets);
        $display("Sets of one to a few hundred samples, idling on both sides and one long hold-off.");
        if (tracker.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
